[sv/cxt_pkg.sv]
`timescale 1ns / 1ps

package cxt_pkg;

   // channel range
   localparam int unsigned CHAN_W = 8;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // register file
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef logic [CHAN_W-1:0]      chan_type;
   typedef logic [CSR_DATA_W-1:0]  color_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SOURCE_COLOR = 2'd0;
   localparam csr_index_type CSR_TARGET_COLOR = 2'd1;
   localparam csr_index_type CSR_TOLERANCE    = 2'd2;

   // packed colour field positions
   localparam int unsigned RED_LSB   = 16;
   localparam int unsigned GREEN_LSB = 8;
   localparam int unsigned BLUE_LSB  = 0;

   // result of one colour channel
   typedef struct packed {
      logic     hit;
      chan_type value;
   } chan_res_type;

endpackage

[sv/cxt_chan.sv]
`timescale 1ns / 1ps

module cxt_chan (
   input  cxt_pkg::chan_type     pix,
   input  cxt_pkg::chan_type     src,
   input  cxt_pkg::chan_type     tol,
   input  cxt_pkg::chan_type     dst,
   output cxt_pkg::chan_res_type res
);

   logic [cxt_pkg::CHAN_W-1:0] lo;
   logic [cxt_pkg::CHAN_W:0]   hi_sum;
   logic [cxt_pkg::CHAN_W-1:0] hi;
   logic [cxt_pkg::CHAN_W-1:0] delta;
   logic [cxt_pkg::CHAN_W:0]   repl_sum;

   // form the window, saturated at both ends
   assign lo     = (src > tol) ? (src - tol) : '0;
   assign hi_sum = {1'b0, src} + {1'b0, tol};
   assign hi     = hi_sum[cxt_pkg::CHAN_W] ? cxt_pkg::CHAN_MAX : hi_sum[cxt_pkg::CHAN_W-1:0];

   // distance from the source colour
   assign delta    = (pix > src) ? (pix - src) : (src - pix);
   assign repl_sum = {1'b0, dst} + {1'b0, delta};

   assign res.hit   = (pix >= lo) && (pix <= hi);
   assign res.value = repl_sum[cxt_pkg::CHAN_W] ? cxt_pkg::CHAN_MAX
                                                : repl_sum[cxt_pkg::CHAN_W-1:0];

endmodule

[sv/color_exchange_tolerance_core.sv]
`timescale 1ns / 1ps

// Colour exchange with tolerance. Each RGBA pixel beat on the req_ channel
// gives exactly one pixel beat on the rsp_ channel, in order. When red, green
// and blue all lie within source colour +/- tolerance (inclusive, clipped to
// 0..255), each colour channel becomes target + |pixel - source|, clipped at
// 255; otherwise the colour passes unchanged. Alpha is always copied. The
// block takes one pixel every cycle while req_stall is low; a pixel taken
// into the input register moves on into the result register once that
// register is free, and is offered on rsp_ from there. A stall on rsp_
// backs up into req_stall only once both registers are full. Write the
// csr_ registers (0 source, 1 target, 2 tolerance; others ignored) only while
// no pixel is in flight.
module color_exchange_tolerance_core (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  cxt_pkg::csr_index_type      csr_index,
   input  cxt_pkg::color_type          csr_data,
   // pixel in
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cxt_pkg::chan_type           req_red_in,
   input  cxt_pkg::chan_type           req_green_in,
   input  cxt_pkg::chan_type           req_blue_in,
   input  cxt_pkg::chan_type           req_alpha_in,
   // pixel out
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cxt_pkg::chan_type           rsp_red_out,
   output cxt_pkg::chan_type           rsp_green_out,
   output cxt_pkg::chan_type           rsp_blue_out,
   output cxt_pkg::chan_type           rsp_alpha_out
);

   cxt_pkg::color_type source_ff, target_ff, tol_ff;

   logic              in_valid_ff, in_valid_in;
   cxt_pkg::chan_type in_red_ff, in_green_ff, in_blue_ff, in_alpha_ff;

   logic              out_valid_ff, out_valid_in;
   cxt_pkg::chan_type out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   cxt_pkg::chan_type out_red_in, out_green_in, out_blue_in;

   logic req_take, out_free, in_move;

   cxt_pkg::chan_res_type red_res, green_res, blue_res;
   logic                  all_hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         target_ff <= '0;
         tol_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            cxt_pkg::CSR_SOURCE_COLOR: source_ff <= csr_data;
            cxt_pkg::CSR_TARGET_COLOR: target_ff <= csr_data;
            cxt_pkg::CSR_TOLERANCE:    tol_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake: the result register frees when empty or being taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
   assign out_valid_in = in_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_red_ff   <= req_red_in;
         in_green_ff <= req_green_in;
         in_blue_ff  <= req_blue_in;
         in_alpha_ff <= req_alpha_in;
      end
   end

   // per-channel window test and replacement
   cxt_chan u_red (
      .pix (in_red_ff),
      .src (source_ff[cxt_pkg::RED_LSB +: cxt_pkg::CHAN_W]),
      .tol (tol_ff[cxt_pkg::RED_LSB +: cxt_pkg::CHAN_W]),
      .dst (target_ff[cxt_pkg::RED_LSB +: cxt_pkg::CHAN_W]),
      .res (red_res)
   );

   cxt_chan u_green (
      .pix (in_green_ff),
      .src (source_ff[cxt_pkg::GREEN_LSB +: cxt_pkg::CHAN_W]),
      .tol (tol_ff[cxt_pkg::GREEN_LSB +: cxt_pkg::CHAN_W]),
      .dst (target_ff[cxt_pkg::GREEN_LSB +: cxt_pkg::CHAN_W]),
      .res (green_res)
   );

   cxt_chan u_blue (
      .pix (in_blue_ff),
      .src (source_ff[cxt_pkg::BLUE_LSB +: cxt_pkg::CHAN_W]),
      .tol (tol_ff[cxt_pkg::BLUE_LSB +: cxt_pkg::CHAN_W]),
      .dst (target_ff[cxt_pkg::BLUE_LSB +: cxt_pkg::CHAN_W]),
      .res (blue_res)
   );

   // replace only when every colour channel matches
   assign all_hit      = red_res.hit && green_res.hit && blue_res.hit;
   assign out_red_in   = all_hit ? red_res.value   : in_red_ff;
   assign out_green_in = all_hit ? green_res.value : in_green_ff;
   assign out_blue_in  = all_hit ? blue_res.value  : in_blue_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
         out_alpha_ff <= in_alpha_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_red_ff;
   assign rsp_green_out = out_green_ff;
   assign rsp_blue_out  = out_blue_ff;
   assign rsp_alpha_out = out_alpha_ff;

endmodule

[sv/cxt_checker.sv]
`timescale 1ns / 1ps

module cxt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input cxt_pkg::chan_type req_alpha_in,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cxt_pkg::chan_type rsp_red_out,
   input cxt_pkg::chan_type rsp_green_out,
   input cxt_pkg::chan_type rsp_blue_out,
   input cxt_pkg::chan_type rsp_alpha_out
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_alpha_out))
      else $error("stalled result beat changed");

   // input backs up only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending result");

   // a taken pixel passes both registers to the output if not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("result beat missing after two cycles");

   // alpha passes through
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_alpha_out == $past(req_alpha_in, 2))
      else $error("alpha not copied");

endmodule

bind color_exchange_tolerance_core cxt_checker u_cxt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_alpha_in  (req_alpha_in),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_alpha_out (rsp_alpha_out)
);
